// File: src/lst_pkg.sv
package lst_pkg;

    // track status codes
    typedef logic [2:0] track_status_t;
    localparam track_status_t ST_STOP   = 3'd0;
    localparam track_status_t ST_LEFT   = 3'd1;
    localparam track_status_t ST_RIGHT  = 3'd2;
    localparam track_status_t ST_LOST   = 3'd3;
    localparam track_status_t ST_FOLLOW = 3'd4;

    // locked turn direction codes
    typedef logic [1:0] lock_dir_t;
    localparam lock_dir_t DIR_NONE  = 2'd0;
    localparam lock_dir_t DIR_LEFT  = 2'd1;
    localparam lock_dir_t DIR_RIGHT = 2'd2;

    // configuration register indexes
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_LOCK_LENGTH      = 2'd0;
    localparam cfg_index_t CFG_CENTRE_POSITION  = 2'd1;
    localparam cfg_index_t CFG_WEIGHT_STEP      = 2'd2;
    localparam cfg_index_t CFG_CORNER_MIN_BLACK = 2'd3;

    localparam int CFG_DATA_W = 16;

    // configuration reset values
    localparam logic [15:0] LOCK_LENGTH_RST      = 16'd150;
    localparam logic [7:0]  CENTRE_POSITION_RST  = 8'd35;
    localparam logic [4:0]  WEIGHT_STEP_RST      = 5'd10;
    localparam logic [3:0]  CORNER_MIN_BLACK_RST = 4'd4;

    // quotient bits retired per divider cycle
    localparam int DIV_RADIX_BITS = 4;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CLASSIFY,
        S_DIVIDE,
        S_OUTPUT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_sample;
        logic classify;
        logic div_step;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic follow;
        logic out_busy;
    } dp_status_t;

endpackage

// File: src/lst_ctrl.sv
module lst_ctrl
    import lst_pkg::*;
#(
    parameter int ITER = 3
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sample_valid,
    output logic       sample_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam int ITER_W = $clog2(ITER + 1);

    ctrl_state_t       state_reg;
    ctrl_state_t       state_next;
    logic [ITER_W-1:0] iter_reg;
    logic [ITER_W-1:0] iter_next;

    // state and divider step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                iter_next = '0;
                if (status.follow)
                begin
                    state_next = S_DIVIDE;
                end
                else
                begin
                    state_next = S_OUTPUT;
                end
            end
            S_DIVIDE:
            begin
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(ITER - 1))
                begin
                    state_next = S_OUTPUT;
                end
            end
            S_OUTPUT:
            begin
                if (!status.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        sample_ready     = 1'b0;
        cmd.load_sample  = 1'b0;
        cmd.classify     = 1'b0;
        cmd.div_step     = 1'b0;
        cmd.load_out     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                sample_ready    = 1'b1;
                cmd.load_sample = sample_valid;
            end
            S_CLASSIFY:
            begin
                cmd.classify = 1'b1;
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            S_OUTPUT:
            begin
                cmd.load_out = !status.out_busy;
            end
            default:
            begin
                sample_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: src/lst_datapath.sv
module lst_datapath
    import lst_pkg::*;
#(
    parameter int CHANNELS = 8,
    parameter int ITER     = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_en,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [CHANNELS-1:0]   sensor_bits,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [7:0]            line_position,
    output track_status_t         track_status
);

    localparam int CNT_W   = $clog2(CHANNELS + 1);
    localparam int IDX_MAX = CHANNELS * (CHANNELS - 1) / 2;
    localparam int IDX_W   = $clog2(IDX_MAX + 1);
    localparam int PROD_W  = IDX_W + 5;
    localparam int NUM_W   = PROD_W + 1;
    localparam int DIV_W   = ITER * DIV_RADIX_BITS;

    // configuration registers
    logic [15:0] lock_length_reg;
    logic [7:0]  centre_position_reg;
    logic [4:0]  weight_step_reg;
    logic [3:0]  corner_min_black_reg;

    // lock state
    lock_dir_t   locked_dir_reg;
    lock_dir_t   locked_dir_next;
    logic [15:0] lock_rem_reg;
    logic [15:0] lock_rem_next;

    // item payload and working registers
    logic [CHANNELS-1:0] sample_reg;
    track_status_t       res_status_reg;
    track_status_t       res_status_next;
    logic [DIV_W-1:0]    div_reg;
    logic [DIV_W-1:0]    div_next;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    rem_next;
    logic [CNT_W-1:0]    divisor_reg;
    logic                out_valid_reg;
    logic [7:0]          out_pos_reg;
    track_status_t       out_status_reg;

    logic [CNT_W-1:0]    black_cnt;
    logic [IDX_W-1:0]    idx_sum;
    logic                lock_active;
    logic                all_black;
    logic                all_white;
    logic                enough_black;
    logic                top_black;
    logic                bottom_black;
    logic                follow;
    logic [PROD_W-1:0]   weighted_sum;
    logic [NUM_W-1:0]    dividend;
    logic [7:0]          quotient_sat;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_length_reg      <= LOCK_LENGTH_RST;
            centre_position_reg  <= CENTRE_POSITION_RST;
            weight_step_reg      <= WEIGHT_STEP_RST;
            corner_min_black_reg <= CORNER_MIN_BLACK_RST;
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                CFG_LOCK_LENGTH:      lock_length_reg      <= cfg_data[15:0];
                CFG_CENTRE_POSITION:  centre_position_reg  <= cfg_data[7:0];
                CFG_WEIGHT_STEP:      weight_step_reg      <= cfg_data[4:0];
                CFG_CORNER_MIN_BLACK: corner_min_black_reg <= cfg_data[3:0];
                default:              lock_length_reg      <= lock_length_reg;
            endcase
        end
    end

    // black channel count and index sum
    always_comb
    begin
        black_cnt = '0;
        idx_sum   = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (!sample_reg[i])
            begin
                black_cnt = black_cnt + 1'b1;
                idx_sum   = idx_sum + IDX_W'(CHANNELS - 1 - i);
            end
        end
    end

    // sample classification
    assign lock_active  = (locked_dir_reg != DIR_NONE) && (lock_rem_reg != '0);
    assign all_black    = (sample_reg == '0);
    assign all_white    = &sample_reg;
    assign top_black    = ~|sample_reg[CHANNELS-1 -: 3];
    assign bottom_black = ~|sample_reg[2:0];
    assign enough_black = {4'b0, black_cnt} >= {{CNT_W{1'b0}}, corner_min_black_reg};

    always_comb
    begin
        locked_dir_next = locked_dir_reg;
        lock_rem_next   = lock_rem_reg;
        res_status_next = ST_FOLLOW;
        follow          = 1'b0;
        if (lock_active)
        begin
            lock_rem_next   = lock_rem_reg - 1'b1;
            res_status_next = {1'b0, locked_dir_reg};
            if (all_black)
            begin
                res_status_next = ST_STOP;
                locked_dir_next = DIR_NONE;
                lock_rem_next   = '0;
            end
        end
        else
        begin
            locked_dir_next = DIR_NONE;
            if (all_black)
            begin
                res_status_next = ST_STOP;
            end
            else if (all_white)
            begin
                res_status_next = ST_LOST;
            end
            else if (top_black && enough_black)
            begin
                res_status_next = ST_LEFT;
                locked_dir_next = DIR_LEFT;
                lock_rem_next   = lock_length_reg;
            end
            else if (bottom_black && enough_black)
            begin
                res_status_next = ST_RIGHT;
                locked_dir_next = DIR_RIGHT;
                lock_rem_next   = lock_length_reg;
            end
            else
            begin
                follow = 1'b1;
            end
        end
    end

    // rounded centroid numerator
    assign weighted_sum = PROD_W'(idx_sum) * PROD_W'(weight_step_reg);
    assign dividend     = NUM_W'(weighted_sum) + NUM_W'(black_cnt >> 1);

    // restoring divider, several quotient bits per cycle
    always_comb
    begin
        logic [DIV_W-1:0] d;
        logic [CNT_W-1:0] r;
        logic [CNT_W:0]   t;
        d = div_reg;
        r = rem_reg;
        t = '0;
        for (int k = 0; k < DIV_RADIX_BITS; k++)
        begin
            t = {r, d[DIV_W-1]};
            d = {d[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, divisor_reg})
            begin
                t    = t - {1'b0, divisor_reg};
                d[0] = 1'b1;
            end
            r = t[CNT_W-1:0];
        end
        div_next = d;
        rem_next = r;
    end

    // saturate quotient to eight bits
    assign quotient_sat = (|div_reg[DIV_W-1:8]) ? 8'hFF : div_reg[7:0];

    // lock state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locked_dir_reg <= DIR_NONE;
            lock_rem_reg   <= '0;
        end
        else if (cmd.classify)
        begin
            locked_dir_reg <= locked_dir_next;
            lock_rem_reg   <= lock_rem_next;
        end
    end

    // item payload and divider registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            sample_reg <= sensor_bits;
        end
        if (cmd.classify)
        begin
            res_status_reg <= res_status_next;
            div_reg        <= DIV_W'(dividend);
            rem_reg        <= '0;
            divisor_reg    <= black_cnt;
        end
        else if (cmd.div_step)
        begin
            div_reg <= div_next;
            rem_reg <= rem_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_pos_reg    <= (res_status_reg == ST_FOLLOW) ? quotient_sat
                                                            : centre_position_reg;
        end
    end

    assign status.follow   = follow;
    assign status.out_busy = out_valid_reg && !result_ready;
    assign result_valid    = out_valid_reg;
    assign line_position   = out_pos_reg;
    assign track_status    = out_status_reg;

endmodule

// File: src/line_sensor_tracker.sv
// channel    direction  signals
// ---------  ---------  ----------------------------------------------
// sample     in         sample_valid, sample_ready, sensor_bits
// result     out        result_valid, result_ready, line_position,
//                       track_status
// config     in         cfg_en, cfg_index, cfg_data (write only)
//
// an item passes through accept, classify and load output, with ITER divider steps after classify
// when the line is followed (ITER = 3 at 8 channels, 4 quotient bits a cycle); load output waits
// while the output register is busy, and the result is valid once the output register is loaded.
// reset clears the lock state and loads the register defaults.
// one item at a time; a result waiting in the output register does not
// block the next sample until the following result is ready to load.
module line_sensor_tracker
    import lst_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_en,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  logic [CHANNELS-1:0]   sensor_bits,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [7:0]            line_position,
    output track_status_t         track_status
);

    localparam int IDX_MAX = CHANNELS * (CHANNELS - 1) / 2;
    localparam int IDX_W   = $clog2(IDX_MAX + 1);
    localparam int NUM_W   = IDX_W + 6;
    localparam int ITER    = (NUM_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencing
    lst_ctrl #(
        .ITER(ITER)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .status       (status),
        .cmd          (cmd)
    );

    // classification, centroid divider and output register
    lst_datapath #(
        .CHANNELS (CHANNELS),
        .ITER     (ITER)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_en        (cfg_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sensor_bits   (sensor_bits),
        .cmd           (cmd),
        .status        (status),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .line_position (line_position),
        .track_status  (track_status)
    );

endmodule
